// ----- rtl/qrcia_pkg.sv -----
// Shared types and constants for the QR codeword interleave address block.
`timescale 1ns / 1ps
package qrcia_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_IDX_AVAIL  = 2'd0;
    localparam logic [1:0] CFG_IDX_BLOCKS = 2'd1;
    localparam logic [1:0] CFG_IDX_EPB    = 2'd2;
    localparam logic [1:0] CFG_IDX_KIND   = 2'd3;

    // Symbol kinds
    localparam logic [1:0] KIND_REGULAR = 2'd0;
    localparam logic [1:0] KIND_MICRO   = 2'd1;
    localparam logic [1:0] KIND_TEN     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [14:0] RST_AVAIL  = 15'd208;
    localparam logic [6:0]  RST_BLOCKS = 7'd1;
    localparam logic [6:0]  RST_EPB    = 7'd7;
    localparam logic [1:0]  RST_KIND   = KIND_REGULAR;

    localparam int WordBits = 13;    // word counts and word indexes
    localparam int DivSteps = WordBits;
    localparam int CfgDivSteps = 15;

    typedef struct packed {
        logic        op;
        logic [14:0] bit_index;
    } t_in;

    typedef struct packed {
        logic [14:0] bit_position;
        logic        past_end;
    } t_out;

    typedef enum logic [1:0] {
        PATH_SHORT,
        PATH_LONG,
        PATH_ECC
    } t_path;

    typedef struct packed {
        t_path      path;
        logic       past_end;
        logic [2:0] u;
    } t_tag;

    // Derived configuration, to be kept stable by the user while items are in flight; the block does not enforce it
    typedef struct packed {
        logic                ws10;
        logic [6:0]          blocks;
        logic [6:0]          epb;
        logic [13:0]         ew;
        logic [WordBits-1:0] dw;
        logic [14:0]         db;
        logic [WordBits-1:0] ds;
        logic [6:0]          lg;
        logic [6:0]          sm;
        logic [WordBits-1:0] dssm;
    } t_cfg_view;

    typedef enum logic [2:0] {
        CFG_START,
        CFG_TW,
        CFG_DS,
        CFG_PROD,
        CFG_IDLE
    } t_cfg_state;

endpackage

// ----- rtl/qr_codeword_interleave_address.sv -----
// Top level of the QR codeword interleave address generator.
`timescale 1ns / 1ps
// Maps a bit index in the de-interleaved data stream (op 0) or error
// correction stream (op 1) to its bit position in the interleaved codeword
// buffer of a QR symbol. The block is a 17-stage pipeline: one input register,
// 13 divider stages (one quotient bit each, splitting the word index into
// block row and column), then products, word offset and the output register.
// It takes one transaction per cycle when not stalled; every stage
// has its own valid bit and stalls only when the stage below is full, so
// bubbles are squeezed out under backpressure. After reset and after every
// configuration write a layout sequencer runs (total word count, one serial
// division of data words by blocks, plus setup) to derive word counts and
// block sizes; input ready stays low while it runs.
// Configuration transactions are always accepted and should be issued only
// with the pipeline empty.
module qr_codeword_interleave_address #(
    parameter int POSITION_BITS = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  qrcia_pkg::t_in    i_in_data,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output qrcia_pkg::t_out   o_out_data,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [14:0]       i_cfg_data
);
    import qrcia_pkg::*;

    t_cfg_view           view;
    logic                cfg_busy;
    logic                front_ready;
    logic                fr_valid, fr_ready;
    logic [WordBits-1:0] fr_num, fr_den;
    t_tag                fr_tag;
    logic                dv_valid, dv_ready;
    logic [WordBits-1:0] dv_quo, dv_rem;
    t_tag                dv_tag;

    assign o_cfg_ready = 1'b1;

    qrcia_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (cfg_busy),
        .o_view      (view)
    );

    // hold off items until the layout is derived
    assign o_in_ready = front_ready && !cfg_busy;

    qrcia_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_view  (view),
        .i_valid (i_in_valid && !cfg_busy),
        .o_ready (front_ready),
        .i_data  (i_in_data),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_num   (fr_num),
        .o_den   (fr_den),
        .o_tag   (fr_tag)
    );

    qrcia_divpipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_num   (fr_num),
        .i_den   (fr_den),
        .i_tag   (fr_tag),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_quo   (dv_quo),
        .o_rem   (dv_rem),
        .o_tag   (dv_tag)
    );

    qrcia_post #(
        .POSITION_BITS (POSITION_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_view  (view),
        .i_valid (dv_valid),
        .o_ready (dv_ready),
        .i_quo   (dv_quo),
        .i_rem   (dv_rem),
        .i_tag   (dv_tag),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // a configuration transaction restarts the layout sequencer
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !o_in_ready)
        else $error("input ready right after a configuration transaction");

    // no item taken in the first cycle out of reset
    a_reset_blocks_input: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("input ready before layout derived");

    // past end results carry a zero position
    a_past_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.past_end) |-> (o_out_data.bit_position == 15'd0))
        else $error("nonzero position on past end result");

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");
`endif

endmodule

// ----- rtl/qrcia_cfg.sv -----
// Configuration registers and sequencer that derives the block layout.
`timescale 1ns / 1ps
module qrcia_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [14:0]          i_cfg_data,
    output logic                 o_busy,
    output qrcia_pkg::t_cfg_view o_view
);
    import qrcia_pkg::*;

    logic [14:0] r_avail;
    logic [6:0]  r_blocks_raw;
    logic [6:0]  r_epb;
    logic [1:0]  r_kind;

    t_cfg_state r_state, n_state;

    // restoring divider for data words over blocks, one quotient bit per cycle
    logic [6:0]  r_dv_rem;
    logic [14:0] r_dv_quo;
    logic [6:0]  r_dv_den;
    logic [3:0]  r_dv_cnt;
    logic        dv_load;
    logic [14:0] dv_num;
    logic [6:0]  dv_den;
    logic        dv_done;
    logic [7:0]  dv_trial;
    logic        dv_ge;

    // bits / 10 by reciprocal multiply, exact for 15-bit operands
    logic [30:0]         tw10_prod;
    logic [WordBits-1:0] r_tw10;

    logic [13:0]         r_ew;
    logic [WordBits-1:0] r_dw;
    logic [14:0]         r_db;
    logic [WordBits-1:0] r_ds;
    logic [6:0]          r_lg;
    logic [6:0]          r_sm;
    logic [WordBits-1:0] r_dssm;

    logic [6:0]          blocks;
    logic                micro;
    logic                ws10;
    logic [15:0]         av_p7;
    logic [WordBits-1:0] tw;
    logic [13:0]         ew;
    logic [13:0]         dw_diff;
    logic [WordBits-1:0] dw;
    logic [16:0]         nib;
    logic [16:0]         ew8;
    logic [16:0]         db_micro;
    logic [16:0]         db_word;
    logic [14:0]         db;
    logic [6:0]          sm;
    logic [19:0]         dssm_full;

    assign blocks = (r_blocks_raw == 7'd0) ? 7'd1 : r_blocks_raw;
    assign micro  = (r_kind == KIND_MICRO);
    assign ws10   = (r_kind == KIND_TEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail      <= RST_AVAIL;
            r_blocks_raw <= RST_BLOCKS;
            r_epb        <= RST_EPB;
            r_kind       <= RST_KIND;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_AVAIL:  r_avail      <= i_cfg_data;
                CFG_IDX_BLOCKS: r_blocks_raw <= i_cfg_data[6:0];
                CFG_IDX_EPB:    r_epb        <= i_cfg_data[6:0];
                CFG_IDX_KIND:   r_kind       <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // divider
    assign dv_done  = (r_dv_cnt == 4'd0);
    assign dv_trial = {r_dv_rem, r_dv_quo[14]};
    assign dv_ge    = (dv_trial >= {1'b0, r_dv_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt <= 4'd0;
        end else if (dv_load) begin
            r_dv_cnt <= 4'(CfgDivSteps);
        end else if (!dv_done) begin
            r_dv_cnt <= r_dv_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_load) begin
            r_dv_rem <= 7'd0;
            r_dv_quo <= dv_num;
            r_dv_den <= dv_den;
        end else if (!dv_done) begin
            r_dv_rem <= dv_ge ? 7'(dv_trial - {1'b0, r_dv_den}) : dv_trial[6:0];
            r_dv_quo <= {r_dv_quo[13:0], dv_ge};
        end
    end

    // 52429 / 2^19 sits just above 1/10
    assign tw10_prod = {16'd0, r_avail} * 31'd52429;

    // layout from the total word count
    assign av_p7   = {1'b0, r_avail} + 16'd7;
    assign tw      = ws10  ? r_tw10 :
                     micro ? av_p7[15:3] : {1'b0, r_avail[14:3]};
    assign ew      = 14'(r_epb * blocks);
    assign dw_diff = {1'b0, tw} - ew;
    assign dw      = ({1'b0, tw} > ew) ? dw_diff[WordBits-1:0] : '0;
    assign nib     = {2'b00, r_avail[14:2], 2'b00};
    assign ew8     = {ew, 3'b000};
    assign db_micro = (nib > ew8) ? (nib - ew8) : 17'd0;
    assign db_word  = {1'b0, dw, 3'b000} + (ws10 ? {3'b000, dw, 1'b0} : 17'd0);
    assign db       = micro ? db_micro[14:0] : db_word[14:0];
    assign sm        = blocks - r_lg;
    assign dssm_full = r_ds * sm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CFG_START;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            CFG_START: n_state = CFG_TW;
            CFG_TW:    n_state = CFG_DS;
            CFG_DS:    if (dv_done) n_state = CFG_PROD;
            CFG_PROD:  n_state = CFG_IDLE;
            CFG_IDLE:  n_state = CFG_IDLE;
            default:   n_state = CFG_START;
        endcase
        if (i_cfg_valid) n_state = CFG_START;
    end

    always_comb begin
        dv_load = (r_state == CFG_TW);
        dv_num  = {2'b00, dw};
        dv_den  = blocks;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == CFG_START) begin
            r_tw10 <= {1'b0, tw10_prod[30:19]};
        end
        if (r_state == CFG_TW) begin
            r_ew <= ew;
            r_dw <= dw;
            r_db <= db;
        end
        if (r_state == CFG_DS && dv_done) begin
            r_ds <= r_dv_quo[WordBits-1:0];
            r_lg <= r_dv_rem;
        end
        if (r_state == CFG_PROD) begin
            r_sm   <= sm;
            r_dssm <= dssm_full[WordBits-1:0];
        end
    end

    assign o_busy = (r_state != CFG_IDLE);

    always_comb begin
        o_view.ws10   = ws10;
        o_view.blocks = blocks;
        o_view.epb    = r_epb;
        o_view.ew     = r_ew;
        o_view.dw     = r_dw;
        o_view.db     = r_db;
        o_view.ds     = r_ds;
        o_view.lg     = r_lg;
        o_view.sm     = r_sm;
        o_view.dssm   = r_dssm;
    end

endmodule

// ----- rtl/qrcia_front.sv -----
// Input stage: range check, stream region select and divider operands.
`timescale 1ns / 1ps
module qrcia_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  qrcia_pkg::t_cfg_view             i_view,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  qrcia_pkg::t_in                   i_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [qrcia_pkg::WordBits-1:0]   o_num,
    output logic [qrcia_pkg::WordBits-1:0]   o_den,
    output qrcia_pkg::t_tag                  o_tag
);
    import qrcia_pkg::*;

    logic                r_valid;
    logic [WordBits-1:0] r_num;
    logic [WordBits-1:0] r_den;
    t_tag                r_tag;

    logic [WordBits-1:0] n;
    logic                short_rgn;
    t_tag                tag;
    logic [WordBits-1:0] num;
    logic [WordBits-1:0] den;

    assign n         = {1'b0, i_data.bit_index[14:3]};
    assign short_rgn = (n < i_view.dssm);

    always_comb begin
        tag.u = i_data.bit_index[2:0];
        if (!i_data.op) begin
            tag.past_end = (n >= i_view.dw);
            tag.path     = short_rgn ? PATH_SHORT : PATH_LONG;
            num          = short_rgn ? n : n - i_view.dssm;
            den          = short_rgn ? i_view.ds : i_view.ds + 1'b1;
        end else begin
            tag.past_end = ({1'b0, n} >= i_view.ew) || (i_view.epb == 7'd0);
            tag.path     = PATH_ECC;
            num          = n;
            den          = {{(WordBits-7){1'b0}}, i_view.epb};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_num <= num;
            r_den <= den;
            r_tag <= tag;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_tag   = r_tag;

endmodule

// ----- rtl/qrcia_divpipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
`timescale 1ns / 1ps
module qrcia_divpipe (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [qrcia_pkg::WordBits-1:0]   i_num,
    input  logic [qrcia_pkg::WordBits-1:0]   i_den,
    input  qrcia_pkg::t_tag                  i_tag,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [qrcia_pkg::WordBits-1:0]   o_quo,
    output logic [qrcia_pkg::WordBits-1:0]   o_rem,
    output qrcia_pkg::t_tag                  o_tag
);
    import qrcia_pkg::*;

    logic                r_v   [DivSteps];
    logic [WordBits-1:0] r_rem [DivSteps];
    logic [WordBits-1:0] r_num [DivSteps];
    logic [WordBits-1:0] r_den [DivSteps];
    t_tag                r_tag [DivSteps];

    logic                rdy   [DivSteps+1];
    logic                v_in  [DivSteps];
    logic [WordBits-1:0] rem_in[DivSteps];
    logic [WordBits-1:0] num_in[DivSteps];
    logic [WordBits-1:0] den_in[DivSteps];
    t_tag                tag_in[DivSteps];

    assign rdy[DivSteps] = i_ready;

    genvar k;
    generate
        for (k = 0; k < DivSteps; k++) begin : g_stage
            logic [WordBits:0] trial;
            logic              ge;

            if (k == 0) begin : g_first
                assign v_in[k]   = i_valid;
                assign rem_in[k] = '0;
                assign num_in[k] = i_num;
                assign den_in[k] = i_den;
                assign tag_in[k] = i_tag;
            end else begin : g_next
                assign v_in[k]   = r_v[k-1];
                assign rem_in[k] = r_rem[k-1];
                assign num_in[k] = r_num[k-1];
                assign den_in[k] = r_den[k-1];
                assign tag_in[k] = r_tag[k-1];
            end

            assign rdy[k] = !r_v[k] || rdy[k+1];
            assign trial  = {rem_in[k], num_in[k][WordBits-1]};
            assign ge     = (trial >= {1'b0, den_in[k]});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (rdy[k]) begin
                    r_v[k] <= v_in[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy[k] && v_in[k]) begin
                    r_rem[k] <= ge ? WordBits'(trial - {1'b0, den_in[k]})
                                   : trial[WordBits-1:0];
                    r_num[k] <= {num_in[k][WordBits-2:0], ge};
                    r_den[k] <= den_in[k];
                    r_tag[k] <= tag_in[k];
                end
            end
        end
    endgenerate

    assign o_ready = rdy[0];
    assign o_valid = r_v[DivSteps-1];
    assign o_quo   = r_num[DivSteps-1];
    assign o_rem   = r_rem[DivSteps-1];
    assign o_tag   = r_tag[DivSteps-1];

endmodule

// ----- rtl/qrcia_post.sv -----
// Back end: column/row to word offset, word size scaling and output register.
`timescale 1ns / 1ps
module qrcia_post #(
    parameter int POSITION_BITS = 15
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  qrcia_pkg::t_cfg_view             i_view,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [qrcia_pkg::WordBits-1:0]   i_quo,
    input  logic [qrcia_pkg::WordBits-1:0]   i_rem,
    input  qrcia_pkg::t_tag                  i_tag,
    output logic                             o_valid,
    input  logic                             i_ready,
    output qrcia_pkg::t_out                  o_data
);
    import qrcia_pkg::*;

    localparam int ProdW = WordBits + 7;
    localparam int SumW  = ProdW + 1;
    localparam int PosW  = SumW + 4;
    localparam logic [PosW-1:0] PosMask = PosW'((64'd1 << POSITION_BITS) - 64'd1);

    // stage A: products
    logic                r_a_v;
    logic [ProdW-1:0]    r_a_p1;
    logic [ProdW-1:0]    r_a_p2;
    logic [WordBits-1:0] r_a_y;
    t_tag                r_a_tag;
    // stage B: word offset
    logic                r_b_v;
    logic [SumW-1:0]     r_b_t;
    t_tag                r_b_tag;
    // stage C: output
    logic                r_c_v;
    t_out                r_c_data;

    logic                rdy_a, rdy_b, rdy_c;
    logic [WordBits:0]   x_p1;
    logic [WordBits-1:0] c;
    logic                is_long;
    logic [6:0]          m1_a;
    logic [WordBits-1:0] m1_b;
    logic [SumW-1:0]     t_sum;
    logic [PosW-1:0]     t_scaled;
    logic [PosW-1:0]     pos;
    logic [PosW-1:0]     pos_masked;

    assign rdy_c = !r_c_v || i_ready;
    assign rdy_b = !r_b_v || rdy_c;
    assign rdy_a = !r_a_v || rdy_b;

    // long blocks: column c = min(x + 1, ds) counts the short blocks ahead
    assign is_long = (i_tag.path == PATH_LONG);
    assign x_p1    = {1'b0, i_rem} + 1'b1;
    assign c       = (x_p1 < {1'b0, i_view.ds}) ? x_p1[WordBits-1:0] : i_view.ds;
    assign m1_a    = is_long ? i_view.sm : i_view.blocks;
    assign m1_b    = is_long ? c : i_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (rdy_a) r_a_v <= i_valid;
            if (rdy_b) r_b_v <= r_a_v;
            if (rdy_c) r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a_p1  <= m1_a * m1_b;
            r_a_p2  <= is_long ? i_view.lg * i_rem : '0;
            r_a_y   <= i_quo;
            r_a_tag <= i_tag;
        end
    end

    assign t_sum = SumW'(r_a_p1) + SumW'(r_a_p2) + SumW'(r_a_y);

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_a_v) begin
            r_b_t   <= t_sum;
            r_b_tag <= r_a_tag;
        end
    end

    // t * 8 or t * 10, plus the data region length on the ECC stream, plus the bit within the word
    assign t_scaled   = {r_b_t, 3'b000} + (i_view.ws10 ? PosW'({r_b_t, 1'b0}) : '0);
    assign pos        = t_scaled
                      + ((r_b_tag.path == PATH_ECC) ? PosW'(i_view.db) : '0)
                      + PosW'(r_b_tag.u);
    assign pos_masked = pos & PosMask;

    always_ff @(posedge i_clk) begin
        if (rdy_c && r_b_v) begin
            r_c_data.past_end     <= r_b_tag.past_end;
            r_c_data.bit_position <= r_b_tag.past_end ? 15'd0 : pos_masked[14:0];
        end
    end

    assign o_ready = rdy_a;
    assign o_valid = r_c_v;
    assign o_data  = r_c_data;

endmodule

// ----- verif/tb_qr_codeword_interleave_address.sv -----
// Testbench for the QR codeword interleave address generator: queued random and edge stimulus.
`timescale 1ns / 1ps
module tb_qr_codeword_interleave_address;
    import qrcia_pkg::*;

    // Symbol kind 3 has no package name; the block treats it as regular
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int HOLD_CYCLES = 80;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    t_in           i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    t_out          o_out_data;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = CFG_IDX_AVAIL;
    logic [14:0]   i_cfg_data = '0;

    // Shadow copy of the configuration registers
    logic [14:0]   avail_bits = RST_AVAIL;
    logic [6:0]    block_cnt = RST_BLOCKS;
    logic [6:0]    ecc_per_block = RST_EPB;
    logic [1:0]    sym_kind = RST_KIND;

    typedef struct {
        longint ws, blocks, epb, ew, dw, db, lg, sm, ds;
    } t_layout;

    t_in   index_q[$];        // items waiting to be offered
    t_out  position_q[$];     // positions expected from the block
    int    fail_count = 0;
    logic  in_took = 1'b0;    // input transaction seen at the last rising edge
    bit    calm = 1'b0;       // no idling in the final phase
    bit    hold_req = 1'b0;
    int    send_gap = 0;
    int    recv_gap = 0;
    int    hold_left = 0;

    qr_codeword_interleave_address uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Word counts and block split for the current configuration
    function automatic t_layout symbol_layout();
        t_layout lay;
        longint tw, nib;
        bit micro;
        micro = (sym_kind == KIND_MICRO);
        lay.ws = (sym_kind == KIND_TEN) ? 10 : 8;
        lay.blocks = (block_cnt == 0) ? 1 : block_cnt;
        lay.epb = ecc_per_block;
        tw = micro ? (avail_bits + 7) / 8 : avail_bits / lay.ws;
        lay.ew = lay.epb * lay.blocks;
        lay.dw = (tw > lay.ew) ? tw - lay.ew : 0;
        if (micro) begin
            nib = avail_bits / 4 * 4;
            lay.db = (nib > lay.ew * 8) ? nib - lay.ew * 8 : 0;
        end else begin
            lay.db = lay.dw * lay.ws;
        end
        lay.lg = lay.dw % lay.blocks;
        lay.sm = lay.blocks - lay.lg;
        lay.ds = lay.dw / lay.blocks;
        return lay;
    endfunction

    // Interleaved buffer position for one stream bit
    function automatic t_out predict_position(t_in it);
        t_layout lay;
        t_out res;
        longint n, u, pos, x, y, m, dl, c;
        bit over;
        lay = symbol_layout();
        n = it.bit_index / 8;
        u = it.bit_index % 8;
        pos = 0;
        over = 1'b0;
        if (it.op == 1'b0) begin
            if (n >= lay.dw) begin
                over = 1'b1;
            end else if (n < lay.ds * lay.sm) begin
                // short blocks: column-major over all blocks
                x = n % lay.ds;
                y = n / lay.ds;
                pos = (x * lay.blocks + y) * lay.ws + u;
            end else begin
                // long blocks: extra word lands after every short column
                m = n - lay.ds * lay.sm;
                dl = lay.ds + 1;
                x = m % dl;
                y = m / dl;
                c = (x + 1 < lay.ds) ? x + 1 : lay.ds;
                pos = (lay.sm * c + lay.lg * x + y) * lay.ws + u;
            end
        end else begin
            if (n >= lay.ew || lay.epb == 0) begin
                over = 1'b1;
            end else begin
                x = n % lay.epb;
                y = n / lay.epb;
                pos = (x * lay.blocks + y) * lay.ws + lay.db + u;
            end
        end
        if (over) pos = 0;
        res.bit_position = pos[14:0];
        res.past_end = over;
        return res;
    endfunction

    // Sender: offer queued items, with short random gaps
    always @(negedge i_clk) begin
        if (!i_in_valid || in_took) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (index_q.size() > 0) begin
                i_in_data <= index_q.pop_front();
                i_in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off to back up the pipe
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 3);
        end
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        t_out want;
        in_took <= i_in_valid && o_in_ready && i_rst_n;
        if (i_rst_n && i_in_valid && o_in_ready) position_q.push_back(predict_position(i_in_data));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (position_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual pos %0d end %0b",
                         $time, o_out_data.bit_position, o_out_data.past_end);
            end else begin
                want = position_q.pop_front();
                if (o_out_data.bit_position !== want.bit_position) begin
                    fail_count++;
                    $display("%0t: bit_position expected %0d actual %0d",
                             $time, want.bit_position, o_out_data.bit_position);
                end
                if (o_out_data.past_end !== want.past_end) begin
                    fail_count++;
                    $display("%0t: past_end expected %0b actual %0b",
                             $time, want.past_end, o_out_data.past_end);
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IDX_AVAIL:  avail_bits = val;
            CFG_IDX_BLOCKS: block_cnt = val[6:0];
            CFG_IDX_EPB:    ecc_per_block = val[6:0];
            default:        sym_kind = val[1:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (index_q.size() > 0 || i_in_valid || position_q.size() > 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic configure(input logic [14:0] av, input logic [6:0] bl,
                             input logic [6:0] ep, input logic [1:0] kd);
        wait_drained();
        write_reg(CFG_IDX_AVAIL, av);
        write_reg(CFG_IDX_BLOCKS, {8'd0, bl});
        write_reg(CFG_IDX_EPB, {8'd0, ep});
        write_reg(CFG_IDX_KIND, {13'd0, kd});
    endtask

    // Mostly indices within or just past the end of the selected stream, some fully random
    task automatic queue_random(input int count);
        t_layout lay;
        t_in it;
        longint span;
        lay = symbol_layout();
        for (int k = 0; k < count; k++) begin
            it.op = 1'($urandom_range(0, 1));
            span = (it.op ? lay.ew : lay.dw) * 8 + 16;
            if (span > 32767) span = 32767;
            if ($urandom_range(0, 7) == 0) it.bit_index = 15'($urandom_range(0, 32767));
            else it.bit_index = 15'($urandom_range(0, int'(span)));
            index_q.push_back(it);
        end
    endtask

    task automatic queue_item(input logic op, input longint idx);
        t_in it;
        it.op = op;
        it.bit_index = idx[14:0];
        index_q.push_back(it);
    endtask

    initial begin
        t_layout lay;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: stream edges and field extremes
        lay = symbol_layout();
        for (int op = 0; op < 2; op++) begin
            queue_item(1'(op), 0);
            queue_item(1'(op), 7);
            queue_item(1'(op), (op ? lay.ew : lay.dw) * 8 - 1);
            queue_item(1'(op), (op ? lay.ew : lay.dw) * 8);
            queue_item(1'(op), 32767);
        end
        queue_random(10);

        // several regular blocks, all short since data words divide evenly; long hold-off here
        configure(15'd1568, 7'd4, 7'd26, KIND_REGULAR);
        hold_req = 1'b1;
        queue_random(50);
        // micro symbol, nibble-rounded data bits
        configure(15'd84, 7'd1, 7'd2, KIND_MICRO);
        queue_random(30);
        configure(15'd1500, 7'd5, 7'd9, KIND_MICRO);
        queue_random(30);
        // 10-bit words at the largest buffer: positions near the top of the field
        configure(15'd32767, 7'd13, 7'd30, KIND_TEN);
        queue_random(40);
        // reserved kind, block count of zero
        configure(15'd3000, 7'd0, 7'd11, KIND_RESERVED);
        queue_random(30);
        // no error words at all
        configure(15'd800, 7'd3, 7'd0, KIND_REGULAR);
        queue_random(25);
        // error words outnumber the buffer, empty data stream
        configure(15'd400, 7'd127, 7'd127, KIND_MICRO);
        queue_random(25);
        configure(15'd0, 7'd127, 7'd1, KIND_TEN);
        queue_random(20);
        // large micro buffer: error words sit just below the top of the field
        configure(15'd32767, 7'd7, 7'd1, KIND_MICRO);
        queue_random(40);
        configure(15'd32767, 7'd127, 7'd127, KIND_REGULAR);
        queue_random(30);
        // final phase, full throughput
        configure(15'd9000, 7'd17, 7'd22, KIND_REGULAR);
        calm = 1'b1;
        queue_random(60);

        wait_drained();
        if (fail_count == 0) begin
            $display("qr_codeword_interleave_address: match");
        end else begin
            $display("qr_codeword_interleave_address: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("qr_codeword_interleave_address: mismatch");
        $finish;
    end

endmodule
